// ===== hdl/six_joint_arm_forward_kinematics_defines.svh =====
// Assertion macros for the arm kinematics block.
// No dependencies.
`ifndef SIX_JOINT_ARM_FORWARD_KINEMATICS_DEFINES_SVH
`define SIX_JOINT_ARM_FORWARD_KINEMATICS_DEFINES_SVH
// implication under clock and reset
`define SJAFK_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sjafk assertion failed");
// next-cycle implication
`define SJAFK_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sjafk assertion failed");
`endif

// ===== hdl/sjafk_pkg.sv =====
// Package for the arm kinematics block: widths, constants, register
// indexes, pipeline structs and fixed-point helpers. No dependencies.
package sjafk_pkg;
  localparam int FracBits = 16;
  localparam int RoundShift = 30 - FracBits;
  localparam int AngW = 20;
  localparam int LenW = 24;
  localparam int OutW = 20;
  localparam int ThW = 23;  // two's complement room for sum of three
  localparam int QW = 32;
  // register stages from input beat to output beat: angle prep, trig, pose
  localparam int PipeDepth = 15;

  localparam logic signed [31:0] TurnsPerRad = 32'sd683565276;
  localparam logic signed [31:0] HalfPiQ30 = 32'sd1686629713;

  typedef enum logic [2:0] {
    RegLenD1A2 = 3'd0,
    RegLenA3D4 = 3'd1,
    RegLenD5D6 = 3'd2,
    RegFlip    = 3'd3,
    RegOffLow  = 3'd4,
    RegOffHigh = 3'd5
  } reg_idx_e;

  typedef logic signed [QW-1:0] q30_t;

  typedef struct packed {
    logic signed [LenW-1:0] d1;
    logic signed [LenW-1:0] a2;
    logic signed [LenW-1:0] a3;
    logic signed [LenW-1:0] d4;
    logic signed [LenW-1:0] d5;
    logic signed [LenW-1:0] d6;
  } len_t;

  typedef struct packed {
    logic en;
    logic hold;
  } pipe_ctl_t;

  // R(a*b,30) for signed values up to 32 bits
  function automatic logic signed [63:0] mq(input logic signed [63:0] a,
                                            input logic signed [63:0] b);
    logic signed [63:0] p;
    p = a * b + 64'sd536870912;
    return p >>> 30;
  endfunction

  function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + (64'sd1 <<< (RoundShift - 1));
    return t >>> RoundShift;
  endfunction

  function automatic logic signed [OutW-1:0] sat(input logic signed [63:0] v);
    if (v > 64'sd524287) return 20'sh7FFFF;
    if (v < -64'sd524288) return 20'sh80000;
    return v[OutW-1:0];
  endfunction
endpackage

// ===== hdl/six_joint_arm_forward_kinematics.sv =====
// Six-joint arm forward kinematics, stream in and out, APB configuration.
// Throughput: one pose per cycle; a stalled output freezes the whole pipe.
// Reset (rst_ni low, asynchronous) clears valid bits and config registers.
// Depends on sjafk_pkg, sjafk_sincos, sjafk_pose and the defines header.
`include "six_joint_arm_forward_kinematics_defines.svh"
module six_joint_arm_forward_kinematics import sjafk_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // joint1_angle..joint6_angle, 20 bits each
  input  logic [119:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // m00 m01 m02 m03 m10 m11 m12 m13 m20 m21 m22 m23, 20 bits each
  output logic [239:0]  m_axis_tdata
);
  logic [47:0] len0_q, len1_q, len2_q;
  logic [5:0]  flip_q;
  logic [59:0] offl_q, offh_q;
  logic [2:0]  idx;
  logic        wr;

  assign pready = 1'b1;
  assign idx = paddr[5:3];
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len0_q <= '0; len1_q <= '0; len2_q <= '0;
      flip_q <= '0; offl_q <= '0; offh_q <= '0;
    end else if (wr) begin
      case (idx)
        RegLenD1A2: len0_q <= pwdata[47:0];
        RegLenA3D4: len1_q <= pwdata[47:0];
        RegLenD5D6: len2_q <= pwdata[47:0];
        RegFlip:    flip_q <= pwdata[5:0];
        RegOffLow:  offl_q <= pwdata[59:0];
        RegOffHigh: offh_q <= pwdata[59:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegLenD1A2: prdata = {16'd0, len0_q};
      RegLenA3D4: prdata = {16'd0, len1_q};
      RegLenD5D6: prdata = {16'd0, len2_q};
      RegFlip:    prdata = {58'd0, flip_q};
      RegOffLow:  prdata = {4'd0, offl_q};
      RegOffHigh: prdata = {4'd0, offh_q};
      default:    prdata = '0;
    endcase
  end

  len_t len;
  assign len = '{d1: len0_q[23:0], a2: len0_q[47:24], a3: len1_q[23:0],
                 d4: len1_q[47:24], d5: len2_q[23:0], d6: len2_q[47:24]};

  pipe_ctl_t ctl;
  logic [PipeDepth-1:0] vld_q;
  assign ctl.hold = vld_q[PipeDepth-1] && !m_axis_tready;
  assign ctl.en = !ctl.hold;
  assign s_axis_tready = ctl.en;
  assign m_axis_tvalid = vld_q[PipeDepth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (ctl.en) vld_q <= {vld_q[PipeDepth-2:0], s_axis_tvalid};
  end

  // stage 0: sign, offset, angle sums
  logic signed [ThW-1:0] th_q [6];
  logic signed [ThW-1:0] th [6];
  logic signed [ThW-1:0] a, o;
  logic [119:0] off_all;
  assign off_all = {offh_q, offl_q};
  always_comb begin
    for (int j = 0; j < 6; j++) begin
      a = ThW'($signed(s_axis_tdata[20*j +: AngW]));
      o = ThW'($signed(off_all[20*j +: AngW]));
      th[j] = (flip_q[j] ? -a : a) - o;
    end
  end
  always_ff @(posedge clk_i) begin
    if (ctl.en) begin
      th_q[0] <= th[0];
      th_q[1] <= th[1];
      th_q[2] <= th[1] + th[2];
      th_q[3] <= th[1] + th[2] + th[3];
      th_q[4] <= th[4];
      th_q[5] <= th[5];
    end
  end

  q30_t sn [6];
  q30_t cs [6];
  for (genvar g = 0; g < 6; g++) begin : g_sc
    sjafk_sincos u_sc (.clk_i, .en_i(ctl.en), .q_i(th_q[g]),
                       .sin_o(sn[g]), .cos_o(cs[g]));
  end

  sjafk_pose u_pose (
    .clk_i, .en_i(ctl.en), .len_i(len),
    .s1_i(sn[0]), .c1_i(cs[0]), .s2_i(sn[1]), .c2_i(cs[1]),
    .s23_i(sn[2]), .c23_i(cs[2]), .s234_i(sn[3]), .c234_i(cs[3]),
    .s5_i(sn[4]), .c5_i(cs[4]), .s6_i(sn[5]), .c6_i(cs[5]),
    .m_o(m_axis_tdata)
  );

  `SJAFK_ASSERT_NXT(a_hold_keeps, ctl.hold, m_axis_tvalid)
  `SJAFK_ASSERT_IMP(a_ready_when_free, !m_axis_tvalid, s_axis_tready)
  `SJAFK_ASSERT_NXT(a_stall_freezes, ctl.hold, $stable(vld_q))
endmodule

// ===== hdl/sjafk_sincos.sv =====
// Pipelined sine/cosine of a Q7.16 angle, Q30 results, ten stages.
// Depends on sjafk_pkg.
module sjafk_sincos import sjafk_pkg::*; (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [ThW-1:0] q_i,
  output q30_t                  sin_o,
  output q30_t                  cos_o
);
  logic [31:0] p_q;
  logic [1:0] k1_q, k2_q, k3_q, k4_q, k5_q, k6_q, k7_q, k8_q;
  logic signed [31:0] r_q;
  logic signed [31:0] x_q, x3_q, x4_q, x5_q, x6_q, x7_q;
  logic signed [31:0] x2_q, x2b_q, x2c_q, x2d_q;
  logic signed [31:0] ps1_q, ps2_q, ps3_q, pc1_q, pc2_q, pc3_q, pc4_q;
  logic signed [31:0] t_q, s_q, c_q;
  logic signed [31:0] sn_q, cs_q;
  logic signed [63:0] prod;
  logic [31:0] p_rot;
  logic [1:0] k;

  assign prod = 64'(q_i) * 64'(TurnsPerRad);
  assign k = 2'((p_q + 32'h2000_0000) >> 30);
  assign p_rot = p_q - {k, 30'd0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q   <= prod[FracBits +: 32];
      k1_q  <= k;
      r_q   <= p_rot;
      k2_q  <= k1_q;
      x_q   <= 32'(mq(64'(r_q), 64'(HalfPiQ30)));
      k3_q  <= k2_q;
      x3_q  <= x_q;
      x2_q  <= 32'(mq(64'(x_q), 64'(x_q)));
      k4_q  <= k3_q;
      x4_q  <= x3_q;
      x2b_q <= x2_q;
      ps1_q <= 32'(64'sd8947849 + mq(-64'sd213044, 64'(x2_q)));
      pc1_q <= 32'(-64'sd1491308 + mq(64'sd26630, 64'(x2_q)));
      k5_q  <= k4_q;
      x5_q  <= x4_q;
      x2c_q <= x2b_q;
      ps2_q <= 32'(-64'sd178956971 + mq(64'(ps1_q), 64'(x2b_q)));
      pc2_q <= 32'(64'sd44739243 + mq(64'(pc1_q), 64'(x2b_q)));
      k6_q  <= k5_q;
      x6_q  <= x5_q;
      x2d_q <= x2c_q;
      ps3_q <= 32'(mq(64'(ps2_q), 64'(x2c_q)));
      pc3_q <= 32'(-64'sd536870912 + mq(64'(pc2_q), 64'(x2c_q)));
      k7_q  <= k6_q;
      x7_q  <= x6_q;
      t_q   <= 32'(mq(64'(ps3_q), 64'(x6_q)));
      pc4_q <= 32'(64'sd1073741824 + mq(64'(pc3_q), 64'(x2d_q)));
      k8_q  <= k7_q;
      s_q   <= x7_q + t_q;
      c_q   <= pc4_q;
      case (k8_q)
        2'd0: begin sn_q <= s_q; cs_q <= c_q; end
        2'd1: begin sn_q <= c_q; cs_q <= -s_q; end
        2'd2: begin sn_q <= -s_q; cs_q <= -c_q; end
        default: begin sn_q <= -c_q; cs_q <= s_q; end
      endcase
    end
  end

  assign sin_o = sn_q;
  assign cos_o = cs_q;
endmodule

// ===== hdl/sjafk_pose.sv =====
// Pipelined pose assembly from joint sines and cosines, four stages.
// Depends on sjafk_pkg.
module sjafk_pose import sjafk_pkg::*; (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  len_t                   len_i,
  input  q30_t                   s1_i, c1_i, s2_i, c2_i, s23_i, c23_i,
  input  q30_t                   s234_i, c234_i, s5_i, c5_i, s6_i, c6_i,
  output logic [12*OutW-1:0]     m_o
);
  // stage A: pairwise products
  q30_t c234c1_q, s234c1_q, c234s1_q, c234c5_q, s234s1_q, s234c5_q;
  q30_t s1s5_q, c5s1_q, c1c5_q, c1s5_q, s234s5_q, c234s6_q, c234c6_q;
  q30_t c23c1_q, c1c2_q, c23s1_q, c2s1_q, s5s234_q, s234c6_q;
  q30_t s1_a_q, c1_a_q, s5_a_q, c5_a_q, s6_a_q, c6_a_q, s23_a_q, s2_a_q, c234_a_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c234c1_q <= 32'(mq(64'(c234_i), 64'(c1_i)));
      s234c1_q <= 32'(mq(64'(s234_i), 64'(c1_i)));
      c234s1_q <= 32'(mq(64'(c234_i), 64'(s1_i)));
      c234c5_q <= 32'(mq(64'(c234_i), 64'(c5_i)));
      s234s1_q <= 32'(mq(64'(s234_i), 64'(s1_i)));
      s234c5_q <= 32'(mq(64'(s234_i), 64'(c5_i)));
      s234c6_q <= 32'(mq(64'(s234_i), 64'(c6_i)));
      s1s5_q   <= 32'(mq(64'(s1_i), 64'(s5_i)));
      c5s1_q   <= 32'(mq(64'(c5_i), 64'(s1_i)));
      c1c5_q   <= 32'(mq(64'(c1_i), 64'(c5_i)));
      c1s5_q   <= 32'(mq(64'(c1_i), 64'(s5_i)));
      s234s5_q <= 32'(mq(64'(s234_i), 64'(s5_i)));
      c234s6_q <= 32'(mq(64'(c234_i), 64'(s6_i)));
      c234c6_q <= 32'(mq(64'(c234_i), 64'(c6_i)));
      c23c1_q  <= 32'(mq(64'(c23_i), 64'(c1_i)));
      c1c2_q   <= 32'(mq(64'(c1_i), 64'(c2_i)));
      c23s1_q  <= 32'(mq(64'(c23_i), 64'(s1_i)));
      c2s1_q   <= 32'(mq(64'(c2_i), 64'(s1_i)));
      s5s234_q <= 32'(mq(64'(s5_i), 64'(s234_i)));
      s1_a_q <= s1_i; c1_a_q <= c1_i; s5_a_q <= s5_i; c5_a_q <= c5_i;
      s6_a_q <= s6_i; c6_a_q <= c6_i; s23_a_q <= s23_i; s2_a_q <= s2_i;
      c234_a_q <= c234_i;
    end
  end

  // stage B: triple products and u, v
  logic signed [63:0] u_q, v_q, r00_q, r10_q, r20_q;
  logic signed [63:0] s234c1s6_q, s234c1c6_q, s234s1s6_q, s234c6s1_q;
  logic signed [63:0] s234c5c6_q, s234c5s6_q, nc234s6_q, c234c6b_q;
  logic signed [63:0] tx_a3_q, tx_a2_q, tx_d5_q, tx_d4_q, ty_d4_q;
  logic signed [63:0] ty_a3_q, ty_a2_q, ty_d5_q, tz_q, tz_d6_q;
  q30_t s6_b_q, c6_b_q;
  logic signed [63:0] d6;
  assign d6 = 64'(len_i.d6);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r00_q <= mq(64'(c234c1_q), 64'(s5_a_q)) - 64'(c5s1_q);
      u_q   <= 64'(s1s5_q) + mq(64'(c234c1_q), 64'(c5_a_q));
      r10_q <= 64'(c1c5_q) + mq(64'(c234s1_q), 64'(s5_a_q));
      v_q   <= 64'(c1s5_q) - mq(64'(c234c5_q), 64'(s1_a_q));
      r20_q <= -64'(s234s5_q);
      s234c1s6_q <= mq(64'(s234c1_q), 64'(s6_a_q));
      s234c1c6_q <= mq(64'(s234c1_q), 64'(c6_a_q));
      s234s1s6_q <= mq(64'(s234s1_q), 64'(s6_a_q));
      s234c6s1_q <= mq(64'(s234c6_q), 64'(s1_a_q));
      s234c5c6_q <= mq(64'(s234c5_q), 64'(c6_a_q));
      s234c5s6_q <= mq(64'(s234c5_q), 64'(s6_a_q));
      nc234s6_q  <= 64'(c234s6_q);
      c234c6b_q  <= 64'(c234c6_q);
      tx_a3_q <= mq(64'(len_i.a3), 64'(c23c1_q));
      tx_a2_q <= mq(64'(len_i.a2), 64'(c1c2_q));
      tx_d5_q <= mq(64'(len_i.d5), 64'(s234c1_q));
      tx_d4_q <= mq(64'(len_i.d4), 64'(s1_a_q));
      ty_d4_q <= mq(64'(len_i.d4), 64'(c1_a_q));
      ty_a3_q <= mq(64'(len_i.a3), 64'(c23s1_q));
      ty_a2_q <= mq(64'(len_i.a2), 64'(c2s1_q));
      ty_d5_q <= mq(64'(len_i.d5), 64'(s234s1_q));
      tz_q    <= 64'(len_i.d1) + mq(64'(len_i.a3), 64'(s23_a_q))
                 + mq(64'(len_i.a2), 64'(s2_a_q)) - mq(64'(len_i.d5), 64'(c234_a_q));
      tz_d6_q <= mq(d6, 64'(s5s234_q));
      s6_b_q <= s6_a_q; c6_b_q <= c6_a_q;
    end
  end

  // stage C: rotation entries and translation sums
  logic signed [63:0] r00_c_q, r01_c_q, r02_c_q, r10_c_q, r11_c_q, r12_c_q;
  logic signed [63:0] r20_c_q, r21_c_q, r22_c_q;
  logic signed [63:0] tx_c_q, ty_c_q, tz_c_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r00_c_q <= r00_q;
      r01_c_q <= mq(64'(c6_b_q), u_q) - s234c1s6_q;
      r02_c_q <= -mq(64'(s6_b_q), u_q) - s234c1c6_q;
      r10_c_q <= r10_q;
      r11_c_q <= -mq(64'(c6_b_q), v_q) - s234s1s6_q;
      r12_c_q <= mq(64'(s6_b_q), v_q) - s234c6s1_q;
      r20_c_q <= r20_q;
      r21_c_q <= -nc234s6_q - s234c5c6_q;
      r22_c_q <= s234c5s6_q - c234c6b_q;
      tx_c_q  <= mq(d6, r00_q) - tx_a3_q - tx_a2_q - tx_d5_q - tx_d4_q;
      ty_c_q  <= mq(d6, r10_q) + ty_d4_q - ty_a3_q - ty_a2_q - ty_d5_q;
      tz_c_q  <= tz_q - tz_d6_q;
    end
  end

  // stage D: rounding and saturation
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_o <= {sat(tz_c_q), sat(rnd(r22_c_q)), sat(rnd(r21_c_q)), sat(rnd(r20_c_q)),
              sat(ty_c_q), sat(rnd(r12_c_q)), sat(rnd(r11_c_q)), sat(rnd(r10_c_q)),
              sat(tx_c_q), sat(rnd(r02_c_q)), sat(rnd(r01_c_q)), sat(rnd(r00_c_q))};
    end
  end
endmodule

// ===== tb/sv/tb_six_joint_arm_forward_kinematics.sv =====
// Testbench for six_joint_arm_forward_kinematics: random joint poses and arm
// geometries, with the expected pose matrix computed in fixed point here.
// Depends on sjafk_pkg for register indexes and widths.
`timescale 1ns / 1ps

class pose_scoreboard;
  logic [239:0] pose_q[$];
  int errors = 0;

  function void note_pose(logic [239:0] m);
    pose_q.insert(pose_q.size(), m);
  endfunction

  function void check_pose(logic [239:0] got);
    logic [239:0] exp_m;
    if (pose_q.size() == 0) begin
      $display("%0t: unexpected pose beat %h", $time, got);
      errors++;
      return;
    end
    exp_m = pose_q.pop_front();
    for (int i = 0; i < 12; i++) begin
      if (exp_m[20*i +: 20] !== got[20*i +: 20]) begin
        $display("%0t: m%0d%0d expected %h actual %h", $time, i / 4, i % 4,
                 exp_m[20*i +: 20], got[20*i +: 20]);
        errors++;
      end
    end
  endfunction
endclass

module tb_six_joint_arm_forward_kinematics;
  import sjafk_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [119:0] s_axis_tdata = '0;  // joint1..joint6 angle, 20 bits each
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [239:0] m_axis_tdata;  // m00..m23 row-major, 20 bits each

  logic [47:0] len_reg[3];
  logic [5:0] flip_reg;
  logic [59:0] off_reg[2];
  int src_idle_pct = 0, dst_stall_pct = 0;
  bit dst_hold = 0;
  longint cycles = 0;
  pose_scoreboard sb = new();

  six_joint_arm_forward_kinematics u_top (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("six_joint_arm_forward_kinematics: mismatch");
      $finish;
    end
  end

  function automatic longint rq(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint mul30(longint a, longint b);
    return rq(a * b, 30);
  endfunction

  function automatic logic [19:0] clip(longint v);
    if (v > 524287) v = 524287;
    if (v < -524288) v = -524288;
    return v[19:0];
  endfunction

  task automatic trig(input longint q, output longint sn, output longint cs);
    logic [63:0] prod;
    logic [31:0] ph, rr;
    logic [1:0] k;
    longint x, x2, ps, pc, s, c;
    prod = q * 64'sd683565276;
    ph = prod[FracBits +: 32];
    k = 2'((ph + 32'h2000_0000) >> 30);
    rr = ph - {k, 30'd0};
    x = rq(longint'($signed(rr)) * 64'sd1686629713, 30);
    x2 = mul30(x, x);
    ps = -213044;
    ps = 8947849 + mul30(ps, x2);
    ps = -178956971 + mul30(ps, x2);
    s = x + mul30(mul30(ps, x2), x);
    pc = 26630;
    pc = -1491308 + mul30(pc, x2);
    pc = 44739243 + mul30(pc, x2);
    pc = -536870912 + mul30(pc, x2);
    c = (64'sd1 <<< 30) + mul30(pc, x2);
    case (k)
      2'd0: begin sn = s; cs = c; end
      2'd1: begin sn = c; cs = -s; end
      2'd2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endtask

  task automatic predict_pose(input logic [119:0] ang, output logic [239:0] m);
    longint th[6], ln[6];
    longint s1, c1, s2, c2, s23, c23, s234, c234, s5, c5, s6, c6;
    longint r00, r01, r02, r10, r11, r12, r20, r21, r22, u, v;
    int rs;
    rs = 30 - FracBits;
    for (int j = 0; j < 6; j++) begin
      th[j] = longint'($signed(ang[20*j +: 20]));
      if (flip_reg[j]) th[j] = -th[j];
      th[j] -= longint'($signed(off_reg[j / 3][20*(j % 3) +: 20]));
      ln[j] = longint'($signed(len_reg[j / 2][24*(j % 2) +: 24]));
    end
    trig(th[0], s1, c1);
    trig(th[1], s2, c2);
    trig(th[1] + th[2], s23, c23);
    trig(th[1] + th[2] + th[3], s234, c234);
    trig(th[4], s5, c5);
    trig(th[5], s6, c6);
    r00 = mul30(mul30(c234, c1), s5) - mul30(c5, s1);
    u = mul30(s1, s5) + mul30(mul30(c234, c1), c5);
    r01 = mul30(c6, u) - mul30(mul30(s234, c1), s6);
    r02 = -mul30(s6, u) - mul30(mul30(s234, c1), c6);
    r10 = mul30(c1, c5) + mul30(mul30(c234, s1), s5);
    v = mul30(c1, s5) - mul30(mul30(c234, c5), s1);
    r11 = -mul30(c6, v) - mul30(mul30(s234, s1), s6);
    r12 = mul30(s6, v) - mul30(mul30(s234, c6), s1);
    r20 = -mul30(s234, s5);
    r21 = -mul30(c234, s6) - mul30(mul30(s234, c5), c6);
    r22 = mul30(mul30(s234, c5), s6) - mul30(c234, c6);
    // ln: d1 a2 a3 d4 d5 d6
    m[19:0] = clip(rq(r00, rs));
    m[39:20] = clip(rq(r01, rs));
    m[59:40] = clip(rq(r02, rs));
    m[79:60] = clip(mul30(ln[5], r00) - mul30(ln[2], mul30(c23, c1))
                    - mul30(ln[1], mul30(c1, c2)) - mul30(ln[4], mul30(s234, c1))
                    - mul30(ln[3], s1));
    m[99:80] = clip(rq(r10, rs));
    m[119:100] = clip(rq(r11, rs));
    m[139:120] = clip(rq(r12, rs));
    m[159:140] = clip(mul30(ln[5], r10) + mul30(ln[3], c1)
                      - mul30(ln[2], mul30(c23, s1)) - mul30(ln[1], mul30(c2, s1))
                      - mul30(ln[4], mul30(s234, s1)));
    m[179:160] = clip(rq(r20, rs));
    m[199:180] = clip(rq(r21, rs));
    m[219:200] = clip(rq(r22, rs));
    m[239:220] = clip(ln[0] + mul30(ln[2], s23) + mul30(ln[1], s2)
                      - mul30(ln[4], c234) - mul30(ln[5], mul30(s5, s234)));
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [63:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 6'(8 * idx);
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegLenD1A2: len_reg[0] = val[47:0];
      RegLenA3D4: len_reg[1] = val[47:0];
      RegLenD5D6: len_reg[2] = val[47:0];
      RegFlip: flip_reg = val[5:0];
      RegOffLow: off_reg[0] = val[59:0];
      RegOffHigh: off_reg[1] = val[59:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pose_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // arm geometry and joint offsets; mode 0 zero, 1 typical, 2 extremes, 3 random
  task automatic setup_arm(input int mode);
    logic [23:0] l[6];
    logic [19:0] o[6];
    for (int i = 0; i < 6; i++) begin
      case (mode)
        0: begin l[i] = '0; o[i] = '0; end
        1: begin l[i] = 24'($urandom_range(0, 65536)); o[i] = 20'($urandom_range(0, 8000)); end
        2: begin l[i] = (i % 2) ? 24'h7FFFFF : 24'h800000;
                 o[i] = (i % 2) ? 20'h80000 : 20'h7FFFF; end
        default: begin l[i] = 24'($urandom); o[i] = 20'($urandom); end
      endcase
    end
    // junk above bit 47 must be ignored
    write_reg(RegLenD1A2, ({$urandom, $urandom} & 64'hFFFF_0000_0000_0000)
                          | 64'({l[1], l[0]}));
    write_reg(RegLenA3D4, 64'({l[3], l[2]}));
    write_reg(RegLenD5D6, 64'({l[5], l[4]}));
    write_reg(RegFlip, mode == 0 ? 64'd0 : mode == 2 ? 64'h3F : 64'($urandom_range(0, 63)));
    write_reg(RegOffLow, 64'({o[2], o[1], o[0]}));
    write_reg(RegOffHigh, 64'({o[5], o[4], o[3]}));
  endtask

  task automatic send_pose(input logic [119:0] ang);
    logic [239:0] m;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= ang;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_pose(ang, m);
    sb.note_pose(m);
    @(negedge clk_i);
  endtask

  function automatic logic [119:0] rand_pose(int kind);
    logic [119:0] a;
    for (int j = 0; j < 6; j++)
      case (kind)
        0: a[20*j +: 20] = 20'($signed($urandom_range(0, 411774)) - 205887);
        default: a[20*j +: 20] = 20'($urandom);
      endcase
    return a;
  endfunction

  always @(negedge clk_i)
    m_axis_tready <= !dst_hold && ($urandom_range(0, 99) >= dst_stall_pct);

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_pose(m_axis_tdata);

  initial begin
    len_reg = '{default: '0};
    off_reg = '{default: '0};
    flip_reg = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset config, extremes, quadrant edges
    send_pose('0);
    send_pose({6{20'h7FFFF}});
    send_pose({6{20'h80000}});
    send_pose({6{20'hFFFFF}});
    send_pose({6{20'd102944}});  // about pi/2
    send_pose({6{20'd51472}});   // about pi/4
    drain();
    setup_arm(2);
    send_pose('0);
    send_pose({6{20'h7FFFF}});
    send_pose({6{20'h80000}});
    send_pose({20'h80000, 20'h7FFFF, 20'h80000, 20'h7FFFF, 20'h0, 20'h7FFFF});
    send_pose({6{20'hAAAAA}});
    send_pose({6{20'h55555}});
    drain();
    setup_arm(1);
    for (int i = 0; i < 8; i++) send_pose(rand_pose(0));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin src_idle_pct = 0; dst_stall_pct = 0; end
        1: begin src_idle_pct = 51; dst_stall_pct = 0; end
        2: begin src_idle_pct = 0; dst_stall_pct = 51; end
        default: begin src_idle_pct = 13; dst_stall_pct = 13; end
      endcase
      setup_arm(ph == 4 ? 2 : ph == 0 ? 0 : ($urandom_range(0, 1) ? 1 : 3));
      if (ph == 1) begin
        fork
          begin dst_hold = 1; repeat (200) @(negedge clk_i); dst_hold = 0; end
        join_none
      end
      for (int i = 0; i < 185; i++)
        send_pose(rand_pose($urandom_range(0, 3) == 0));
      drain();
    end

    if (sb.errors == 0) begin
      $display("six_joint_arm_forward_kinematics: match");
    end else begin
      $display("six_joint_arm_forward_kinematics: mismatch");
    end
    $finish;
  end
endmodule
